[design/ccsv_pkg.sv]
// ----------------------------------------------------------------------------
// ccsv_pkg
// Types and constants shared by the controller CSV record parser modules.
// ----------------------------------------------------------------------------
package ccsv_pkg;

    // one input beat: a character or an end-of-line marker
    typedef struct packed {
        logic [7:0] ch;
        logic       end_line;
    } t_in_item;

    // one result beat, emitted per end of line
    typedef struct packed {
        logic               line_ok;
        logic [31:0]        sequence_res;
        logic signed [15:0] stick1_x;
        logic signed [15:0] stick1_y;
        logic signed [15:0] stick2_x;
        logic signed [15:0] stick2_y;
        logic [7:0]         buttons;
    } t_out_item;

    // field numbers within a line
    localparam logic [2:0] FldTag       = 3'd0;
    localparam logic [2:0] FldSeq       = 3'd1;
    localparam logic [2:0] FldAxisFirst = 3'd2;
    localparam logic [2:0] FldAxisLast  = 3'd5;
    localparam logic [2:0] FldButtons   = 3'd6;

    // progress through the tag "A1"
    localparam logic [1:0] TagNone = 2'd0;
    localparam logic [1:0] TagA    = 2'd1;
    localparam logic [1:0] TagDone = 2'd2;

    // characters of interest
    localparam logic [7:0] ChComma = 8'h2C;
    localparam logic [7:0] ChTagA  = 8'h41;
    localparam logic [7:0] ChTag1  = 8'h31;
    localparam logic [7:0] ChZero  = 8'h30;
    localparam logic [7:0] ChNine  = 8'h39;
    localparam logic [7:0] ChPlus  = 8'h2B;
    localparam logic [7:0] ChMinus = 8'h2D;
    localparam logic [7:0] ChSpace = 8'h20;
    localparam logic [7:0] ChTab   = 8'h09;
    localparam logic [7:0] ChCr    = 8'h0D;

    // magnitude saturates at 2^32, so 33 bits hold it
    localparam int unsigned MagWidth = 33;
    localparam logic [MagWidth-1:0] MagCap      = 33'h1_0000_0000;
    localparam logic [MagWidth-1:0] AxisLimit   = 33'd32767;
    localparam logic [MagWidth-1:0] ButtonLimit = 33'd255;

endpackage

[design/ccsv_parse_core.sv]
// ----------------------------------------------------------------------------
// ccsv_parse_core
// Per-line parse state: tag match, decimal accumulation, field checks and
// held field values. Updates once per taken beat and presents the result of
// an end-of-line beat combinationally.
// ----------------------------------------------------------------------------
module ccsv_parse_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_take,
    input  ccsv_pkg::t_in_item  i_item,
    output logic                o_res_valid,
    output ccsv_pkg::t_out_item o_res
);

    logic [2:0]                       r_field,      n_field;
    logic [1:0]                       r_tag_pos,    n_tag_pos;
    logic [ccsv_pkg::MagWidth-1:0]    r_mag,        n_mag;
    logic                             r_minus,      n_minus;
    logic                             r_begun,      n_begun;
    logic                             r_digit_seen, n_digit_seen;
    logic                             r_line_bad,   n_line_bad;
    logic [31:0]                      r_seq,        n_seq;
    logic [15:0]                      r_axis [4];
    logic [15:0]                      n_axis [4];

    logic                             w_fin_bad;
    logic [15:0]                      w_axis_val;
    logic [2:0]                       w_axis_off;
    logic [1:0]                       w_axis_idx;
    logic [ccsv_pkg::MagWidth+3:0]    w_mag_x10;
    logic [7:0]                       w_ch;
    logic                             w_is_digit;
    logic                             w_is_space;
    logic                             w_ok;

    // character classes
    assign w_ch       = i_item.ch;
    assign w_is_digit = w_ch inside {[ccsv_pkg::ChZero:ccsv_pkg::ChNine]};
    assign w_is_space = w_ch inside {ccsv_pkg::ChSpace, [ccsv_pkg::ChTab:ccsv_pkg::ChCr]};

    // check of the field now open
    always_comb begin
        w_fin_bad = 1'b0;
        if (r_field == ccsv_pkg::FldTag) begin
            w_fin_bad = (r_tag_pos != ccsv_pkg::TagDone);
        end else if (!r_digit_seen) begin
            w_fin_bad = 1'b1;
        end else if (r_field == ccsv_pkg::FldSeq) begin
            w_fin_bad = r_minus || r_mag[ccsv_pkg::MagWidth-1];
        end else if (r_field <= ccsv_pkg::FldAxisLast) begin
            w_fin_bad = (r_mag > ccsv_pkg::AxisLimit);
        end else begin
            w_fin_bad = r_minus ? (r_mag != '0) : (r_mag > ccsv_pkg::ButtonLimit);
        end
    end

    assign w_axis_val = r_minus ? (16'd0 - r_mag[15:0]) : r_mag[15:0];
    assign w_axis_off = r_field - ccsv_pkg::FldAxisFirst;
    assign w_axis_idx = w_axis_off[1:0];

    // times ten plus the new digit
    assign w_mag_x10 = ({4'd0, r_mag} << 3) + ({4'd0, r_mag} << 1)
                     + {{(ccsv_pkg::MagWidth){1'b0}}, w_ch[3:0]};

    // result of an end-of-line beat
    assign w_ok        = !r_line_bad && (r_field == ccsv_pkg::FldButtons) && !w_fin_bad;
    assign o_res_valid = i_take && i_item.end_line;

    always_comb begin
        o_res.line_ok      = w_ok;
        o_res.sequence_res = w_ok ? r_seq : 32'd0;
        o_res.stick1_x     = w_ok ? r_axis[0] : 16'd0;
        o_res.stick1_y     = w_ok ? r_axis[1] : 16'd0;
        o_res.stick2_x     = w_ok ? r_axis[2] : 16'd0;
        o_res.stick2_y     = w_ok ? r_axis[3] : 16'd0;
        o_res.buttons      = w_ok ? r_mag[7:0] : 8'd0;
    end

    // next state for one beat
    always_comb begin
        n_field      = r_field;
        n_tag_pos    = r_tag_pos;
        n_mag        = r_mag;
        n_minus      = r_minus;
        n_begun      = r_begun;
        n_digit_seen = r_digit_seen;
        n_line_bad   = r_line_bad;
        n_seq        = r_seq;
        n_axis       = r_axis;
        if (i_take) begin
            if (i_item.end_line) begin
                // line done, start over
                n_field      = ccsv_pkg::FldTag;
                n_tag_pos    = ccsv_pkg::TagNone;
                n_mag        = '0;
                n_minus      = 1'b0;
                n_begun      = 1'b0;
                n_digit_seen = 1'b0;
                n_line_bad   = 1'b0;
            end else if (!r_line_bad) begin
                if (w_ch == ccsv_pkg::ChComma) begin
                    if (r_field >= ccsv_pkg::FldButtons) begin
                        n_line_bad = 1'b1;
                    end else begin
                        if (w_fin_bad) begin
                            n_line_bad = 1'b1;
                        end else if (r_field == ccsv_pkg::FldSeq) begin
                            n_seq = r_mag[31:0];
                        end else if (r_field != ccsv_pkg::FldTag) begin
                            n_axis[w_axis_idx] = w_axis_val;
                        end
                        n_field      = r_field + 3'd1;
                        n_mag        = '0;
                        n_minus      = 1'b0;
                        n_begun      = 1'b0;
                        n_digit_seen = 1'b0;
                    end
                end else if (r_field == ccsv_pkg::FldTag) begin
                    // tag must read exactly "A1"
                    if (r_tag_pos == ccsv_pkg::TagNone && w_ch == ccsv_pkg::ChTagA) begin
                        n_tag_pos = ccsv_pkg::TagA;
                    end else if (r_tag_pos == ccsv_pkg::TagA && w_ch == ccsv_pkg::ChTag1) begin
                        n_tag_pos = ccsv_pkg::TagDone;
                    end else begin
                        n_line_bad = 1'b1;
                    end
                end else if (w_is_digit) begin
                    if (w_mag_x10 > {4'd0, ccsv_pkg::MagCap}) begin
                        n_mag = ccsv_pkg::MagCap;
                    end else begin
                        n_mag = w_mag_x10[ccsv_pkg::MagWidth-1:0];
                    end
                    n_begun      = 1'b1;
                    n_digit_seen = 1'b1;
                end else if (!r_begun && w_is_space) begin
                    // leading whitespace skipped
                end else if (!r_begun && (w_ch == ccsv_pkg::ChPlus || w_ch == ccsv_pkg::ChMinus)) begin
                    n_begun = 1'b1;
                    n_minus = (w_ch == ccsv_pkg::ChMinus);
                    if (w_ch == ccsv_pkg::ChMinus && r_field == ccsv_pkg::FldSeq) begin
                        n_line_bad = 1'b1;
                    end
                end else begin
                    n_line_bad = 1'b1;
                end
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field      <= ccsv_pkg::FldTag;
            r_tag_pos    <= ccsv_pkg::TagNone;
            r_mag        <= '0;
            r_minus      <= 1'b0;
            r_begun      <= 1'b0;
            r_digit_seen <= 1'b0;
            r_line_bad   <= 1'b0;
        end else begin
            r_field      <= n_field;
            r_tag_pos    <= n_tag_pos;
            r_mag        <= n_mag;
            r_minus      <= n_minus;
            r_begun      <= n_begun;
            r_digit_seen <= n_digit_seen;
            r_line_bad   <= n_line_bad;
        end
    end

    // held field values
    always_ff @(posedge i_clk) begin
        r_seq  <= n_seq;
        r_axis <= n_axis;
    end

endmodule

[design/controller_csv_record_parser.sv]
// ----------------------------------------------------------------------------
// controller_csv_record_parser
// Parses "A1,<seq>,<x1>,<y1>,<x2>,<y2>,<buttons>" lines one character a beat.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_item): one beat per
//   character, or one beat with end_line set to close the line. Characters
//   give no output; every end-of-line beat gives exactly one output beat.
//   Output channel (o_out_valid / i_out_stall / o_out_item): line_ok plus
//   the parsed fields; all fields read zero when line_ok is 0.
//   Throughput: one input beat per cycle, sustained while no end-of-line
//   beat is stalled. An accepted end-of-line beat goes through the input
//   register, then the result register, before it shows at the output.
//   Stalls: a character beat never waits on the output side. An
//   end-of-line beat waits in the input register while the result register
//   is full and stalled; o_in_stall is then raised.
//   Reset (i_rst_n low, synchronous): both registers empty and the parser
//   back at the start of a line.
// ----------------------------------------------------------------------------
module controller_csv_record_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  ccsv_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output ccsv_pkg::t_out_item o_out_item
);

    logic                r_in_valid;
    ccsv_pkg::t_in_item  r_in_item;
    logic                r_out_valid;
    ccsv_pkg::t_out_item r_out_item;

    logic                w_advance;
    logic                w_res_valid;
    ccsv_pkg::t_out_item w_res;

    // the held beat moves on unless it needs a result slot that is busy
    assign w_advance  = r_in_valid
                     && (!r_in_item.end_line || !r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_item <= i_in_item;
        end
    end

    ccsv_parse_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (w_advance),
        .i_item      (r_in_item),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid) begin
            r_out_item <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Bench for the controller CSV record parser. Lines are fed one character a
// beat and closed by an end-of-line beat. Each output beat is checked field
// by field against the oldest pending record, which a behavioral line parser
// in the bench predicts unless a typed directed row gives it. Directed lines
// come first, then random records, mostly well formed with random values, the
// rest carrying one flaw each. Four phases vary source gaps and sink stalls.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int HOLD_CYCLES    = 400;
    localparam int QUIET_LIMIT    = 5000;
    localparam int PHASE_BEATS    = 100;
    localparam int PHASE_LINES    = 3;
    localparam int DRAIN_CYCLES   = 8;

    // known records
    localparam ccsv_pkg::t_out_item REJECT = '0;
    localparam ccsv_pkg::t_out_item ALL_ZERO_OK =
        ccsv_pkg::t_out_item'{1'b1, 32'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 8'd0};
    localparam ccsv_pkg::t_out_item SEQ_ONE_OK =
        ccsv_pkg::t_out_item'{1'b1, 32'd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 8'd0};
    localparam ccsv_pkg::t_out_item FULL_SCALE_OK =
        ccsv_pkg::t_out_item'{1'b1, 32'hFFFF_FFFF, 16'sd32767, -16'sd32767,
                              16'sd32767, -16'sd32767, 8'd255};

    typedef byte unsigned t_char_q[$];

    typedef struct {
        string               txt;
        bit                  typed;
        ccsv_pkg::t_out_item want;
    } t_dir_row;

    typedef enum int {
        FLAW_NONE,
        FLAW_AXIS_RANGE,
        FLAW_BTN_RANGE,
        FLAW_SEQ_RANGE,
        FLAW_SEQ_MINUS,
        FLAW_FEW,
        FLAW_MANY,
        FLAW_EMPTY,
        FLAW_SIGN_ONLY,
        FLAW_TRAIL,
        FLAW_TAG,
        FLAW_NOISE,
        FLAW_DROP,
        FLAW_GARBAGE
    } t_flaw;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    ccsv_pkg::t_in_item  i_in_item = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    ccsv_pkg::t_out_item o_out_item;

    ccsv_pkg::t_out_item pending_records[$];
    t_dir_row  dir_table[$];
    int        mismatches = 0;
    int        beats_sent = 0;
    int        quiet_cycles = 0;
    int        idle_pct = 0;
    int        stall_pct = 0;
    int        hold_asked = 0;
    int        hold_taken = 0;
    int        hold_left = 0;

    // line parser state
    logic [2:0]      rec_field;
    logic [1:0]      rec_tag;
    longint unsigned rec_mag;
    bit              rec_minus;
    bit              rec_begun;
    bit              rec_digit;
    bit              rec_bad;
    logic [31:0]     rec_seq;
    logic [15:0]     rec_axis [4];
    logic [7:0]      rec_btn;

    controller_csv_record_parser uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_item (o_out_item)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // line parser
    // ------------------------------------------------------------------
    task automatic clear_field();
        rec_mag   = 0;
        rec_minus = 1'b0;
        rec_begun = 1'b0;
        rec_digit = 1'b0;
    endtask

    task automatic clear_record();
        clear_field();
        rec_field = ccsv_pkg::FldTag;
        rec_tag   = ccsv_pkg::TagNone;
        rec_bad   = 1'b0;
        rec_seq   = '0;
        rec_btn   = '0;
        foreach (rec_axis[i]) rec_axis[i] = '0;
    endtask

    // range check of the field just closed, value kept if good
    task automatic close_field();
        logic [15:0] axis_val;
        if (rec_field == ccsv_pkg::FldTag) begin
            if (rec_tag != ccsv_pkg::TagDone) rec_bad = 1'b1;
        end else if (!rec_digit) begin
            rec_bad = 1'b1;
        end else if (rec_field == ccsv_pkg::FldSeq) begin
            if (rec_minus || rec_mag >= ccsv_pkg::MagCap) rec_bad = 1'b1;
            else rec_seq = rec_mag[31:0];
        end else if (rec_field <= ccsv_pkg::FldAxisLast) begin
            if (rec_mag > ccsv_pkg::AxisLimit) begin
                rec_bad = 1'b1;
            end else begin
                axis_val = rec_mag[15:0];
                if (rec_minus) axis_val = -axis_val;
                rec_axis[2'(rec_field - ccsv_pkg::FldAxisFirst)] = axis_val;
            end
        end else begin
            // minus only allowed on a zero button mask
            if (rec_minus ? (rec_mag != 0) : (rec_mag > ccsv_pkg::ButtonLimit))
                rec_bad = 1'b1;
            else rec_btn = rec_mag[7:0];
        end
    endtask

    task automatic parse_beat(input ccsv_pkg::t_in_item beat, output bit has_res,
                              output ccsv_pkg::t_out_item res);
        logic [7:0] c;
        c       = beat.ch;
        has_res = 1'b0;
        res     = REJECT;
        if (!beat.end_line && !rec_bad) begin
            if (c == ccsv_pkg::ChComma) begin
                if (rec_field >= ccsv_pkg::FldButtons) begin
                    rec_bad = 1'b1;
                end else begin
                    close_field();
                    rec_field = rec_field + 1'b1;
                    clear_field();
                end
            end else if (rec_field == ccsv_pkg::FldTag) begin
                if (rec_tag == ccsv_pkg::TagNone && c == ccsv_pkg::ChTagA)
                    rec_tag = ccsv_pkg::TagA;
                else if (rec_tag == ccsv_pkg::TagA && c == ccsv_pkg::ChTag1)
                    rec_tag = ccsv_pkg::TagDone;
                else rec_bad = 1'b1;
            end else if (c >= ccsv_pkg::ChZero && c <= ccsv_pkg::ChNine) begin
                rec_mag = rec_mag * 10 + (c - ccsv_pkg::ChZero);
                if (rec_mag > ccsv_pkg::MagCap) rec_mag = ccsv_pkg::MagCap;
                rec_begun = 1'b1;
                rec_digit = 1'b1;
            end else if (!rec_begun && (c == ccsv_pkg::ChSpace ||
                         (c >= ccsv_pkg::ChTab && c <= ccsv_pkg::ChCr))) begin
                // leading whitespace skipped
            end else if (!rec_begun &&
                         (c == ccsv_pkg::ChPlus || c == ccsv_pkg::ChMinus)) begin
                rec_begun = 1'b1;
                rec_minus = (c == ccsv_pkg::ChMinus);
                if (rec_minus && rec_field == ccsv_pkg::FldSeq) rec_bad = 1'b1;
            end else begin
                rec_bad = 1'b1;
            end
        end else if (beat.end_line) begin
            if (!rec_bad) begin
                if (rec_field == ccsv_pkg::FldButtons) close_field();
                else rec_bad = 1'b1;
            end
            has_res = 1'b1;
            if (!rec_bad) begin
                res.line_ok      = 1'b1;
                res.sequence_res = rec_seq;
                res.stick1_x     = rec_axis[0];
                res.stick1_y     = rec_axis[1];
                res.stick2_x     = rec_axis[2];
                res.stick2_y     = rec_axis[3];
                res.buttons      = rec_btn;
            end
            clear_record();
        end
    endtask

    // ------------------------------------------------------------------
    // line text
    // ------------------------------------------------------------------
    // '~' in a line stands for a NUL byte
    function automatic t_char_q text_chars(string txt);
        t_char_q      q;
        byte unsigned c;
        for (int i = 0; i < txt.len(); i++) begin
            c = txt[i];
            if (c == "~") c = 8'h00;
            q.push_back(c);
        end
        return q;
    endfunction

    // decimal field with optional leading whitespace, sign and zeros
    function automatic string num_text(bit neg, longint unsigned mag);
        string s;
        string ws_set;
        int    j;
        s      = "";
        ws_set = "\011\012\013\014\015 ";
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) begin
                j = $urandom_range(0, 5);
                s = {s, ws_set.substr(j, j)};
            end
        end
        if (neg) s = {s, "-"};
        else if ($urandom_range(0, 3) == 0) s = {s, "+"};
        if ($urandom_range(0, 7) == 0) s = {s, "00"};
        return $sformatf("%s%0d", s, mag);
    endfunction

    function automatic string record_text(t_flaw flaw);
        string           f [7];
        string           line;
        string           trail_set;
        int              k;
        int              nfld;
        longint unsigned mag;
        trail_set = " \011+-x.";
        f[0] = "A1";
        case ($urandom_range(0, 3))
            0: mag = $urandom_range(0, 999);
            1: mag = 64'hFFFF_FFFF;
            default: mag = $urandom;
        endcase
        f[1] = num_text(1'b0, mag);
        for (k = 2; k <= 5; k++) begin
            case ($urandom_range(0, 5))
                0: mag = ccsv_pkg::AxisLimit;
                1: mag = 0;
                2: mag = $urandom_range(0, 9);
                default: mag = $urandom_range(0, 32767);
            endcase
            f[k] = num_text($urandom_range(0, 1), mag);
        end
        mag  = ($urandom_range(0, 4) == 0) ? ccsv_pkg::ButtonLimit : $urandom_range(0, 255);
        f[6] = num_text(mag == 0 && $urandom_range(0, 1), mag);
        nfld = 7;

        // one flaw per record, applied to the text
        case (flaw)
            FLAW_AXIS_RANGE:
                f[$urandom_range(2, 5)] =
                    num_text($urandom_range(0, 1), $urandom_range(32768, 99999));
            FLAW_BTN_RANGE: begin
                if ($urandom_range(0, 1)) f[6] = num_text(1'b0, $urandom_range(256, 99999));
                else f[6] = num_text(1'b1, $urandom_range(1, 255));
            end
            FLAW_SEQ_RANGE: begin
                if ($urandom_range(0, 1)) begin
                    f[1] = num_text(1'b0, ccsv_pkg::MagCap + $urandom_range(0, 999));
                end else begin
                    // long enough to saturate the magnitude
                    f[1] = $sformatf("%0d", $urandom_range(1, 9));
                    repeat ($urandom_range(10, 24))
                        f[1] = $sformatf("%s%0d", f[1], $urandom_range(0, 9));
                end
            end
            FLAW_SEQ_MINUS: f[1] = num_text(1'b1, $urandom_range(0, 9999));
            FLAW_FEW: nfld = $urandom_range(1, 6);
            FLAW_EMPTY: begin
                k = $urandom_range(0, 6);
                if ($urandom_range(0, 1)) f[k] = "";
                else f[k] = " ";
            end
            FLAW_SIGN_ONLY: begin
                k = $urandom_range(1, 6);
                if ($urandom_range(0, 1)) f[k] = "-";
                else f[k] = " +";
            end
            FLAW_TRAIL: begin
                k    = $urandom_range(0, 6);
                nfld = $urandom_range(0, 5);
                f[k] = {f[k], trail_set.substr(nfld, nfld)};
                nfld = 7;
            end
            FLAW_TAG: begin
                case ($urandom_range(0, 5))
                    0: f[0] = "A";
                    1: f[0] = "A11";
                    2: f[0] = "a1";
                    3: f[0] = "B1";
                    4: f[0] = " A1";
                    default: f[0] = "1A";
                endcase
            end
            default: begin
            end
        endcase

        line = f[0];
        for (k = 1; k < nfld; k++) line = {line, ",", f[k]};
        if (flaw == FLAW_MANY) begin
            repeat ($urandom_range(1, 2))
                line = {line, ",", num_text(1'b0, $urandom_range(0, 99))};
        end
        return line;
    endfunction

    // ------------------------------------------------------------------
    // source side
    // ------------------------------------------------------------------
    task automatic send_beat(input ccsv_pkg::t_in_item beat);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_in_valid <= 1'b0;
            i_in_item  <= ccsv_pkg::t_in_item'($urandom);
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= beat;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) @(posedge i_clk);
        beats_sent++;
    endtask

    task automatic send_line(input t_char_q chars, input bit typed,
                             input ccsv_pkg::t_out_item want);
        ccsv_pkg::t_in_item  beat;
        ccsv_pkg::t_out_item got;
        bit                  has_res;
        foreach (chars[i]) begin
            beat.ch       = chars[i];
            beat.end_line = 1'b0;
            send_beat(beat);
            parse_beat(beat, has_res, got);
        end
        // character bits on an end-of-line beat are don't-care
        beat.ch       = 8'($urandom_range(0, 255));
        beat.end_line = 1'b1;
        send_beat(beat);
        parse_beat(beat, has_res, got);
        pending_records.push_back(typed ? want : got);
    endtask

    // drop valid and wait for every pending record
    task automatic drain_records();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_records.size() != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // sink side: random stalls, plus one long hold on request
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (hold_taken != hold_asked) begin
            hold_taken = hold_asked;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // record checker
    // ------------------------------------------------------------------
    task automatic check_field(string name, logic signed [63:0] want,
                               logic signed [63:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        ccsv_pkg::t_out_item want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (pending_records.size() == 0) begin
                $display("%0t: record with none pending, expected nothing, actual %p",
                         $time, o_out_item);
                mismatches++;
            end else begin
                want = pending_records.pop_front();
                check_field("line_ok", want.line_ok, o_out_item.line_ok);
                check_field("sequence_res", want.sequence_res, o_out_item.sequence_res);
                check_field("stick1_x", want.stick1_x, o_out_item.stick1_x);
                check_field("stick1_y", want.stick1_y, o_out_item.stick1_y);
                check_field("stick2_x", want.stick2_x, o_out_item.stick2_x);
                check_field("stick2_y", want.stick2_y, o_out_item.stick2_y);
                check_field("buttons", want.buttons, o_out_item.buttons);
            end
        end
    end

    // watchdog on cycles with no beat moving
    always @(posedge i_clk) begin
        if ((i_in_valid === 1'b1 && o_in_stall === 1'b0) ||
            (o_out_valid === 1'b1 && i_out_stall === 1'b0)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial begin
        int      idle_sched [4];
        int      stall_sched [4];
        int      lines;
        int      start_beats;
        t_flaw   flaw;
        t_char_q chars;

        idle_sched  = '{0, 58, 0, 22};
        stall_sched = '{0, 0, 58, 22};
        clear_record();

        // directed lines
        dir_table.push_back('{"", 1'b1, REJECT});
        dir_table.push_back('{"A1,0,0,0,0,0,0", 1'b1, ALL_ZERO_OK});
        dir_table.push_back('{"A1,4294967295,32767,-32767,32767,-32767,255", 1'b1,
                              FULL_SCALE_OK});
        dir_table.push_back('{"A1,4294967296,1,2,3,4,5", 1'b1, REJECT});
        dir_table.push_back('{"A1,123456789012345678901234,0,0,0,0,0", 1'b1, REJECT});
        dir_table.push_back('{"A1,7,32768,0,0,0,0", 1'b1, REJECT});
        dir_table.push_back('{"A1,7,0,-32768,0,0,0", 1'b1, REJECT});
        dir_table.push_back('{"A1,7,0,0,0,0,256", 1'b1, REJECT});
        dir_table.push_back('{"A1,7,0,0,0,0,-1", 1'b1, REJECT});
        dir_table.push_back('{"A1,-0,0,0,0,0,0", 1'b1, REJECT});
        dir_table.push_back('{"A1,1,-0,+0,0,0,-0", 1'b1, SEQ_ONE_OK});
        dir_table.push_back('{"A1,1,2,3,4,5,6,7", 1'b1, REJECT});
        dir_table.push_back('{"A1,1,2,3,4,5", 1'b1, REJECT});
        dir_table.push_back('{"A1,,2,3,4,5,6", 1'b1, REJECT});
        dir_table.push_back('{"A1,1,-,3,4,5,6", 1'b1, REJECT});
        dir_table.push_back('{"A1,1,2 ,3,4,5,6", 1'b1, REJECT});
        dir_table.push_back('{"A1,1,+-2,3,4,5,6", 1'b1, REJECT});
        dir_table.push_back('{"A1,\011\012\013\014\015 +42,  -7,+8,\0119,10, 200", 1'b0,
                              REJECT});
        dir_table.push_back('{"A12,1,2,3,4,5,6", 1'b1, REJECT});
        dir_table.push_back('{"B1,1,2,3,4,5,6", 1'b1, REJECT});
        dir_table.push_back('{"A1,1,2,3,4~,5,6", 1'b1, REJECT});
        dir_table.push_back('{"A1,000000000000000000004,-1,1,-32767,32767,128", 1'b0,
                              REJECT});
        dir_table.push_back('{"A1,1,2,3,4,5,6", 1'b0, REJECT});
        dir_table.push_back('{"A", 1'b1, REJECT});
        dir_table.push_back('{"A1,1,2,3,4,5,6 ", 1'b1, REJECT});

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_table[r])
            send_line(text_chars(dir_table[r].txt), dir_table[r].typed, dir_table[r].want);
        drain_records();

        // random records, one phase per idling mix
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct    = idle_sched[ph];
            stall_pct   = stall_sched[ph];
            lines       = 0;
            start_beats = beats_sent;
            while (beats_sent - start_beats < PHASE_BEATS || lines < PHASE_LINES) begin
                // long sink hold while the source keeps going
                if (ph == 0 && lines == 1) hold_asked++;
                if ($urandom_range(0, 99) < 70) flaw = FLAW_NONE;
                else flaw = t_flaw'($urandom_range(FLAW_AXIS_RANGE, FLAW_GARBAGE));
                chars = text_chars(record_text(flaw));
                case (flaw)
                    FLAW_NOISE:
                        chars.insert($urandom_range(0, chars.size()),
                                     8'($urandom_range(0, 255)));
                    FLAW_DROP:
                        if (chars.size() > 0) chars.delete($urandom_range(0, chars.size() - 1));
                    FLAW_GARBAGE: begin
                        chars.delete();
                        repeat ($urandom_range(0, 12))
                            chars.push_back(8'($urandom_range(0, 255)));
                    end
                    default: begin
                    end
                endcase
                send_line(chars, 1'b0, REJECT);
                lines++;
            end
            drain_records();
        end

        idle_pct  = 0;
        stall_pct = 0;
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end

endmodule

[controller_csv_record_parser.f]
design/ccsv_pkg.sv
design/ccsv_parse_core.sv
design/controller_csv_record_parser.sv
bench/tb_top.sv
